@@ hw/rtl/mtp_pkg.sv @@
// Shared constants and the output tempering function of the MT19937 generator.
// No dependencies; used by the core and its checker.
package mtp_pkg;

	localparam int WORD_W = 32;
	localparam int N_WORDS = 624;
	localparam int IDX_W = 10;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_WORDS - 1);
	localparam logic [IDX_W-1:0] EXHAUSTED = IDX_W'(N_WORDS);
	localparam logic [IDX_W-1:0] FAR_SHIFT = IDX_W'(397);
	localparam logic [IDX_W-1:0] FAR_SPLIT = IDX_W'(227);

	localparam logic [WORD_W-1:0] MATRIX_A = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] INIT_MUL = 32'd1812433253;
	localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc6_0000;
	localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

@@ hw/rtl/mtp_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module mtp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/mersenne_twister_prng_core.sv @@
// MT19937 generator core: seeding, in-place twist and tempered draws.
// Depends on mtp_pkg and two mtp_ram instances that hold identical store copies.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------
//   in       | in_valid / in_stall  | restart
//   out      | out_valid / out_stall| random_word
//   config   | cfg_we               | cfg_wdata (seed)
//
// A plain draw: accept, then the registered store read is tempered into the output register.
// Seeding writes one store word per cycle through the seed multiplier.
// A twist runs one priming read (S_PRIME), the 624 word updates (S_TWIST) and S_TWLAST to finish the last write.
// Reset leaves the store unseeded; the first draw after reset always seeds.
// A stalled result sits in the output register while the next beat is accepted.
module mersenne_twister_prng_core
	import mtp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] random_word
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SEED   = 6'b000010,
		S_PRIME  = 6'b000100,
		S_TWIST  = 6'b001000,
		S_TWLAST = 6'b010000,
		S_FETCH  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] seed_q;
	logic              seeded_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  k_q;
	logic [WORD_W-1:0] p_q;
	logic [WORD_W-1:0] cur_q;
	logic              v_s1;
	logic [IDX_W-1:0]  k_s1;
	logic              out_valid_q;
	logic [WORD_W-1:0] random_word_q;

	logic              in_take;
	logic              out_free;
	logic [WORD_W-1:0] seed_mix;
	logic [WORD_W-1:0] seed_word;
	logic [WORD_W-1:0] twist_y;
	logic [WORD_W-1:0] twist_word;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  raddr_a;
	logic [IDX_W-1:0]  raddr_b;
	logic [WORD_W-1:0] rdata_a;
	logic [WORD_W-1:0] rdata_b;

	assign in_stall = (state_q != S_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign random_word = random_word_q;

	assign seed_mix = p_q ^ (p_q >> 30);
	assign seed_word = (k_q == '0) ? seed_q :
		WORD_W'(INIT_MUL * seed_mix) + {{(WORD_W-IDX_W){1'b0}}, k_q};

	assign twist_y = (cur_q & UPPER_MASK) | (rdata_a & LOWER_MASK);
	assign twist_word = rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : '0);

	assign ram_we = (state_q == S_SEED) || v_s1;
	assign ram_waddr = (state_q == S_SEED) ? k_q : k_s1;
	assign ram_wdata = (state_q == S_SEED) ? seed_word : twist_word;

	always_comb begin
		raddr_a = pos_q;
		raddr_b = '0;
		case (state_q)
			S_PRIME, S_TWLAST: begin
				raddr_a = '0;
			end
			S_TWIST: begin
				raddr_a = (k_q == LAST_IDX) ? '0 : k_q + 1'b1;
				raddr_b = (k_q < FAR_SPLIT) ? k_q + FAR_SHIFT : k_q - FAR_SPLIT;
			end
			default: begin
				raddr_a = pos_q;
			end
		endcase
	end

	mtp_ram #(.WIDTH(WORD_W), .DEPTH(N_WORDS)) u_ram_a (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(raddr_a),
		.rdata(rdata_a)
	);

	mtp_ram #(.WIDTH(WORD_W), .DEPTH(N_WORDS)) u_ram_b (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(raddr_b),
		.rdata(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seed_q <= SEED_RESET;
			seeded_q <= 1'b0;
			pos_q <= EXHAUSTED;
			k_q <= '0;
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			v_s1 <= (state_q == S_TWIST);
			if (state_q == S_FETCH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						k_q <= '0;
						if (restart || !seeded_q) begin
							state_q <= S_SEED;
						end else if (pos_q == EXHAUSTED) begin
							state_q <= S_PRIME;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_SEED: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_IDX) begin
						seeded_q <= 1'b1;
						pos_q <= EXHAUSTED;
						state_q <= S_PRIME;
					end
				end
				S_PRIME: begin
					k_q <= '0;
					state_q <= S_TWIST;
				end
				S_TWIST: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_IDX) begin
						state_q <= S_TWLAST;
					end
				end
				S_TWLAST: begin
					pos_q <= '0;
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (out_free) begin
						pos_q <= pos_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		cur_q <= rdata_a;
		if (state_q == S_SEED) begin
			p_q <= seed_word;
		end
		if (state_q == S_FETCH && out_free) begin
			random_word_q <= temper(rdata_a);
		end
	end

endmodule

@@ hw/rtl/mtp_checker.sv @@
// Port-level checker for the MT19937 core, attached by the bind at the end of this file.
// Depends on mtp_pkg for the word width.
module mtp_checker
	import mtp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] random_word
);

	logic [1:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_beat} - {1'b0, out_beat};
		end
	end

	// Every result beat belongs to an input beat that has not been answered yet.
	a_out_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown with no outstanding input beat");

	// One item in the output register and one at work is the most the core holds.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more input beats outstanding than the core can hold");

	// An accepted beat keeps the input closed while it is being worked on.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> in_stall)
		else $error("input accepted again directly after a beat");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat withdrawn while stalled");

	a_out_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(random_word))
		else $error("result word changed while stalled");

endmodule

bind mersenne_twister_prng_core mtp_checker u_mtp_checker (.*);
